/* src/dtfp_pkg.sv */
`default_nettype none

package dtfp_pkg;

  // Default sizes of the number format.
  localparam int FRAC_BITS_DEF   = 16;
  localparam int INT_BITS_DEF    = 31;
  localparam int FRAC_DIGITS_DEF = 5;

  // Output word width and log2 of the bound on the magnitude it may carry.
  localparam int OUT_W       = 48;
  localparam int OUT_MAX_LOG = 47;

  // Character codes the parser recognizes.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    K_DIGIT    = 3'd0,
    K_POINT    = 3'd1,
    K_SIGN_POS = 3'd2,
    K_SIGN_NEG = 3'd3,
    K_BAD      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] fixed_value;
    logic [1:0]              status;
  } out_item_t;

  // Classified character as it travels through the queue.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  // Weight of fraction digit k: round(2^fb / 10^k), worked out at elaboration.
  function automatic logic [63:0] frac_weight(input int k, input int fb);
    logic [63:0] w;
    w = 64'd1 << (fb + 1);
    for (int i = 0; i < 8; i++) begin
      if (i < k) begin
        w = w / 64'd10;
      end
    end
    return (w + 64'd1) >> 1;
  endfunction

endpackage

`default_nettype wire

/* src/dtfp_front.sv */
`default_nettype none

module dtfp_front
  import dtfp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          push,
  output cmd_t          push_cmd,
  input  wire logic     q_ready
);

  logic at_first_r;
  logic at_first_nxt;

  // A character is taken whenever the queue has room.
  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // Classify the character; a sign counts only as the first character.
  always_comb begin
    push_cmd.last  = in_item.is_last;
    push_cmd.digit = 4'(in_item.char_code - CH_ZERO);
    if (at_first_r && in_item.char_code == CH_MINUS) begin
      push_cmd.kind = K_SIGN_NEG;
    end else if (at_first_r && in_item.char_code == CH_PLUS) begin
      push_cmd.kind = K_SIGN_POS;
    end else if (in_item.char_code == CH_POINT) begin
      push_cmd.kind = K_POINT;
    end else if (in_item.char_code >= CH_ZERO && in_item.char_code <= CH_NINE) begin
      push_cmd.kind = K_DIGIT;
    end else begin
      push_cmd.kind = K_BAD;
    end
  end

  // The character after a last one starts a new number.
  assign at_first_nxt = push ? in_item.is_last : at_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_first_r <= 1'b1;
    end else begin
      at_first_r <= at_first_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/dtfp_queue.sv */
`default_nettype none

module dtfp_queue
  import dtfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      q_ready,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] count_nxt;

  assign q_ready = (count_r != 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping for the two-entry queue.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* src/dtfp_back.sv */
`default_nettype none

module dtfp_back
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int INT_BITS    = INT_BITS_DEF,
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  localparam int FRAC_W = FRAC_BITS + 1;
  localparam int POS_W  = $clog2(FRAC_DIGITS + 1);
  localparam int NV_W   = INT_BITS + 4;
  localparam int MAG_W  = INT_BITS + FRAC_BITS + 1;
  localparam int LIM_LOG = (INT_BITS + FRAC_BITS < OUT_MAX_LOG) ?
                           (INT_BITS + FRAC_BITS) : OUT_MAX_LOG;
  localparam logic [MAG_W-1:0] LIMIT = MAG_W'((64'd1 << LIM_LOG) - 64'd1);
  localparam logic [POS_W-1:0] POS_END = POS_W'(FRAC_DIGITS);

  // Weight table: entry p serves the fraction digit taken at position p+1.
  logic [FRAC_BITS-1:0] weight_tbl [2**POS_W];

  for (genvar g = 0; g < 2**POS_W; g++) begin : g_weight
    localparam logic [63:0] W = (g < FRAC_DIGITS) ? frac_weight(g + 1, FRAC_BITS) : 64'd0;
    assign weight_tbl[g] = FRAC_BITS'(W);
  end

  // Parse state.
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                neg_r, neg_nxt;
  logic                pt_r, pt_nxt;
  status_t             err_r, err_nxt;

  // Finish stage: snapshot of a completed number.
  logic                f_valid_r, f_valid_nxt;
  logic [INT_BITS-1:0] f_int_r;
  logic [FRAC_W-1:0]   f_frac_r;
  logic                f_neg_r;
  status_t             f_err_r;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic                o_free;
  logic                f_free;
  logic [NV_W-1:0]     nv;
  logic [FRAC_W-1:0]   frac_sum;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    mag_lim;
  logic [63:0]         mag_ext;
  logic                sat;

  // Handshake chain: output, finish stage, then the queue.
  assign o_free    = !out_valid_r || out_ready;
  assign f_free    = !f_valid_r || o_free;
  assign pop       = q_valid && (!q_cmd.last || f_free);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Digit arithmetic: value*10+digit and the weighted fraction digit.
  assign nv = NV_W'({int_r, 3'b000}) + NV_W'({int_r, 1'b0}) + NV_W'(q_cmd.digit);
  assign frac_sum = frac_r + FRAC_W'(q_cmd.digit * weight_tbl[pos_r]);

  // Character execution.
  always_comb begin
    int_nxt  = int_r;
    frac_nxt = frac_r;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    pt_nxt   = pt_r;
    err_nxt  = err_r;
    if (pop && err_r != ST_INVALID) begin
      unique case (q_cmd.kind)
        K_SIGN_NEG: neg_nxt = 1'b1;
        K_SIGN_POS: neg_nxt = 1'b0;
        K_POINT: begin
          if (pt_r) begin
            err_nxt = ST_INVALID;
          end
          pt_nxt = 1'b1;
        end
        K_DIGIT: begin
          if (pt_r) begin
            if (pos_r < POS_END) begin
              pos_nxt  = pos_r + POS_W'(1);
              frac_nxt = frac_sum;
            end
          end else if (nv[NV_W-1:INT_BITS] != 4'd0) begin
            int_nxt = '1;
            err_nxt = ST_OVERFLOW;
          end else begin
            int_nxt = nv[INT_BITS-1:0];
          end
        end
        default: err_nxt = ST_INVALID;
      endcase
    end
  end

  // A last character moves the number to the finish stage.
  always_comb begin
    f_valid_nxt = f_valid_r;
    if (pop && q_cmd.last) begin
      f_valid_nxt = 1'b1;
    end else if (o_free) begin
      f_valid_nxt = 1'b0;
    end
  end

  // Final scaling, range limit and sign.
  always_comb begin
    mag     = {1'b0, f_int_r, {FRAC_BITS{1'b0}}} + MAG_W'(f_frac_r);
    sat     = (f_err_r == ST_OVERFLOW) || (mag > LIMIT);
    mag_lim = sat ? LIMIT : mag;
    mag_ext = 64'(mag_lim);
    if (f_err_r == ST_INVALID) begin
      out_item_nxt.fixed_value = '0;
      out_item_nxt.status      = ST_INVALID;
    end else begin
      out_item_nxt.fixed_value = f_neg_r ? OUT_W'(64'd0 - mag_ext) : OUT_W'(mag_ext);
      out_item_nxt.status      = sat ? ST_OVERFLOW : ST_OK;
    end
    out_valid_nxt = out_valid_r;
    if (o_free) begin
      out_valid_nxt = f_valid_r;
    end
  end

  // Control state; parse state clears after each last character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      frac_r      <= '0;
      pos_r       <= '0;
      neg_r       <= 1'b0;
      pt_r        <= 1'b0;
      err_r       <= ST_OK;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f_valid_r   <= f_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop && q_cmd.last) begin
        int_r  <= '0;
        frac_r <= '0;
        pos_r  <= '0;
        neg_r  <= 1'b0;
        pt_r   <= 1'b0;
        err_r  <= ST_OK;
      end else begin
        int_r  <= int_nxt;
        frac_r <= frac_nxt;
        pos_r  <= pos_nxt;
        neg_r  <= neg_nxt;
        pt_r   <= pt_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop && q_cmd.last) begin
      f_int_r  <= int_nxt;
      f_frac_r <= frac_nxt;
      f_neg_r  <= neg_nxt;
      f_err_r  <= err_nxt;
    end
    if (o_free && f_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/decimal_text_to_fixed_point.sv */
// Decimal text to fixed-point parser, one ASCII character per transaction.
// Throughput: one character per cycle while the queue has room. After a number's last
// character is taken, its result passes the queue, finish stage and output register.
// Latency is set by the queue between classifier and executor plus two result stages.
// Reset (rst_n low, synchronous) empties the queue and clears all parse state.
`default_nettype none

module decimal_text_to_fixed_point
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int INT_BITS    = INT_BITS_DEF,
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  logic push;
  cmd_t push_cmd;
  logic q_ready;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // Front end: takes characters and classifies them.
  dtfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  // Short queue between front and back.
  dtfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back end: accumulates and forms the result.
  dtfp_back #(
    .FRAC_BITS   (FRAC_BITS),
    .INT_BITS    (INT_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
